FILE: design/ofnd_pkg.sv
package ofnd_pkg;

	// Field kinds as sampled with a field's first word
	localparam logic [2:0] KIND_BYTE   = 3'd0;
	localparam logic [2:0] KIND_WORD   = 3'd1;
	localparam logic [2:0] KIND_LONG   = 3'd2;
	localparam logic [2:0] KIND_SELF   = 3'd3;
	localparam logic [2:0] KIND_SHORT  = 3'd4;
	localparam logic [2:0] KIND_EXT    = 3'd5;
	localparam logic [2:0] KIND_SIZED  = 3'd6;
	localparam logic [2:0] KIND_UNUSED = 3'd7;

	// Extended number prefixes
	localparam logic [7:0] PFX_WORD = 8'h81;
	localparam logic [7:0] PFX_PAIR = 8'h84;
	localparam logic [7:0] PFX_LONG = 8'h88;

	// Sized item length codes meaning four bytes and zero bytes
	localparam logic [1:0] LEN_FOUR = 2'd3;
	localparam logic [1:0] LEN_ZERO = 2'd0;

	// Decoder state carried between words
	typedef struct packed {
		logic [31:0] acc;
		logic [2:0]  taken;
		logic [2:0]  expected;
		logic [2:0]  kind;
		logic        busy;
		logic        fill;
	} ofnd_state_t;

	// Result of one word step
	typedef struct packed {
		logic        emit;
		logic [31:0] value;
		logic        consumed;
	} ofnd_result_t;

endpackage

FILE: design/ofnd_step.sv
module ofnd_step
	import ofnd_pkg::*;
(
	input  logic [2:0]   op,
	input  logic [2:0]   size_code,
	input  logic [7:0]   data_byte,
	input  logic         low_byte_first,
	input  ofnd_state_t  cur,
	output ofnd_state_t  nxt,
	output ofnd_result_t res
);

	function automatic logic [15:0] pair_val(input logic [7:0] a, input logic [7:0] b,
			input logic lbf);
		pair_val = lbf ? {b, a} : {a, b};
	endfunction

	// Next state and result for one word
	always_comb begin
		ofnd_state_t st;
		logic        early;
		logic        hold;
		logic        done;
		logic [7:0]  b0, b1, b2, b3;
		logic [31:0] quad;
		logic [31:0] val;

		st    = cur;
		early = 1'b0;
		hold  = 1'b0;
		done  = 1'b0;
		val   = '0;
		res   = '0;

		// Field start: sample kind and set up length
		if (!cur.busy) begin
			st.kind  = (op == KIND_UNUSED) ? KIND_BYTE : op;
			st.acc   = '0;
			st.taken = '0;
			st.fill  = 1'b0;
			st.busy  = 1'b1;
			case (st.kind)
				KIND_WORD:  st.expected = 3'd2;
				KIND_LONG:  st.expected = 3'd4;
				KIND_SELF:  st.expected = 3'd4;
				KIND_SHORT: st.expected = data_byte[7] ? 3'd2 : 3'd1;
				KIND_EXT: begin
					hold = 1'b1;
					if (data_byte == PFX_WORD) begin
						st.expected = 3'd2;
					end else if (data_byte == PFX_PAIR) begin
						st.expected = 3'd4;
						st.fill     = 1'b1;
					end else if (data_byte == PFX_LONG) begin
						st.expected = 3'd4;
					end else begin
						early        = 1'b1;
						res.value    = {24'd0, data_byte};
						res.consumed = 1'b1;
					end
				end
				KIND_SIZED: begin
					if (size_code[1:0] == LEN_ZERO) begin
						early        = 1'b1;
						res.value    = {32{size_code[2]}};
						res.consumed = 1'b0;
					end
					st.expected = (size_code[1:0] == LEN_FOUR) ? 3'd4 : {1'b0, size_code[1:0]};
					st.fill     = (size_code[1:0] == LEN_FOUR) ? 1'b0 : size_code[2];
				end
				default: st.expected = 3'd1;
			endcase
		end

		// Shift the word into the accumulator
		if (!early && !hold) begin
			st.acc   = st.acc | ({24'd0, data_byte} << {st.taken[1:0], 3'b000});
			st.taken = st.taken + 3'd1;
		end

		b0   = st.acc[7:0];
		b1   = st.acc[15:8];
		b2   = st.acc[23:16];
		b3   = st.acc[31:24];
		quad = low_byte_first ? st.acc : {b0, b1, b2, b3};

		// Completion test
		if (st.kind == KIND_SELF) begin
			case (st.taken)
				3'd1:    done = !b0[7];
				3'd2:    done = !b0[6];
				3'd3:    done = !b0[5];
				default: done = 1'b1;
			endcase
		end else begin
			done = (st.taken >= st.expected);
		end

		// Value assembly
		case (st.kind)
			KIND_WORD: val = {16'd0, pair_val(b0, b1, low_byte_first)};
			KIND_LONG: val = quad;
			KIND_SELF: begin
				case (st.taken)
					3'd0, 3'd1: val = {24'd0, b0};
					3'd2:       val = {17'd0, b0[6:0], b1};
					3'd3:       val = {10'd0, b0[5:0], b1, b2};
					default:    val = {3'd0, b0[4:0], b1, b2, b3};
				endcase
			end
			KIND_SHORT: val = (st.taken <= 3'd1) ? {24'd0, b0} : {17'd0, b0[6:0], b1};
			KIND_EXT: begin
				if (st.expected == 3'd2)
					val = {16'd0, pair_val(b0, b1, low_byte_first)};
				else if (st.fill)
					val = {pair_val(b2, b3, low_byte_first), pair_val(b0, b1, low_byte_first)};
				else
					val = quad;
			end
			KIND_SIZED: begin
				if (st.expected == 3'd1)
					val = {{24{st.fill}}, b0};
				else if (st.expected == 3'd2)
					val = {{16{st.fill}}, pair_val(b0, b1, low_byte_first)};
				else
					val = quad;
			end
			default: val = {24'd0, b0};
		endcase

		if (early) begin
			res.emit = 1'b1;
			st.busy  = 1'b0;
		end else if (!hold && done) begin
			res.emit     = 1'b1;
			res.value    = val;
			res.consumed = 1'b1;
			st.busy      = 1'b0;
		end

		nxt = st;
	end

endmodule

FILE: design/object_field_number_decoder_core.sv
// Object field number decoder. Takes one stream byte per word on the input
// channel and returns one 32-bit value per completed field. A result goes
// through the input register, then the decode step into the result register.
// The field decode between those two registers sets the rate: a word is taken
// every cycle at full rate, one word per clock, held off only while the result
// register waits. low_byte_first is to be written through cfg_wr_en /
// cfg_wr_data by the user only while idle; the block does not enforce it.
module object_field_number_decoder_core
	import ofnd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  op,
	input  logic [2:0]  size_code,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] value,
	output logic        consumed
);

	logic         lbf_q;
	logic         vld_s1;
	logic [2:0]   op_s1;
	logic [2:0]   code_s1;
	logic [7:0]   data_s1;
	ofnd_state_t  state_q;
	ofnd_state_t  state_nxt;
	ofnd_result_t step_res;
	logic         out_vld_q;
	logic [31:0]  value_q;
	logic         consumed_q;
	logic         adv_s1;
	logic         in_take;
	logic         out_take;

	// Handshake
	assign out_take = out_vld_q && !out_stall;
	assign adv_s1   = vld_s1 && (!out_vld_q || !out_stall);
	assign in_stall = vld_s1 && !adv_s1;
	assign in_take  = in_valid && !in_stall;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lbf_q <= 1'b1;
		end else if (cfg_wr_en) begin
			lbf_q <= cfg_wr_data;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_take) begin
			vld_s1 <= 1'b1;
		end else if (adv_s1) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			op_s1   <= op;
			code_s1 <= size_code;
			data_s1 <= data_byte;
		end
	end

	// Decode step
	ofnd_step u_step (
		.op             (op_s1),
		.size_code      (code_s1),
		.data_byte      (data_s1),
		.low_byte_first (lbf_q),
		.cur            (state_q),
		.nxt            (state_nxt),
		.res            (step_res)
	);

	// Field state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv_s1) begin
			state_q <= state_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv_s1 && step_res.emit) begin
			out_vld_q <= 1'b1;
		end else if (out_take) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && step_res.emit) begin
			value_q    <= step_res.value;
			consumed_q <= step_res.consumed;
		end
	end

	assign out_valid = out_vld_q;
	assign value     = value_q;
	assign consumed  = consumed_q;

	// Checks
	a_taken_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.busy |-> state_q.taken <= 3'd4)
		else $error("field byte count out of range");

	a_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && step_res.emit |=> !state_q.busy)
		else $error("field still busy after result");

	a_zero_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && !consumed_q |-> value_q == 32'd0 || value_q == 32'hFFFF_FFFF)
		else $error("unconsumed word gave a non-fill value");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !adv_s1 |=> vld_s1 && $stable(data_s1))
		else $error("held input word lost");

endmodule

FILE: tb/tb_object_field_number_decoder_core.sv
module tb_object_field_number_decoder_core;
	import ofnd_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	// settle time after the last value is back, before config writes
	localparam int SETTLE = 6;
	localparam int HOLD_CYCLES = 80;
	localparam int PHASE_WORDS = 175;

	// Tracks decoder state, predicts each field value and checks returned words
	class field_value_board;
		bit          lbf;
		logic [31:0] acc;
		logic [2:0]  taken;
		logic [2:0]  need;
		logic [2:0]  kind;
		bit          busy;
		bit          fill;
		logic [31:0] exp_value[$];
		bit          exp_used[$];
		int          errors;
		int          checked;

		function new();
			lbf = 1'b1;
			acc = '0;
			taken = '0;
			need = '0;
			kind = KIND_BYTE;
			busy = 1'b0;
			fill = 1'b0;
			errors = 0;
			checked = 0;
		endfunction

		function logic [7:0] byte_of(int i);
			return acc[i*8 +: 8];
		endfunction

		function logic [15:0] pair(logic [7:0] a, logic [7:0] b);
			return lbf ? {b, a} : {a, b};
		endfunction

		function logic [31:0] quad();
			return lbf ? acc : {byte_of(0), byte_of(1), byte_of(2), byte_of(3)};
		endfunction

		function logic [31:0] field_value();
			logic [7:0] b0, b1, b2, b3;
			b0 = byte_of(0);
			b1 = byte_of(1);
			b2 = byte_of(2);
			b3 = byte_of(3);
			case (kind)
				KIND_WORD: return {16'h0, pair(b0, b1)};
				KIND_LONG: return quad();
				KIND_SELF: begin
					if (taken <= 3'd1) return {24'h0, b0};
					if (taken == 3'd2) return {17'h0, b0[6:0], b1};
					if (taken == 3'd3) return {10'h0, b0[5:0], b1, b2};
					return {3'h0, b0[4:0], b1, b2, b3};
				end
				KIND_SHORT: begin
					if (taken <= 3'd1) return {24'h0, b0};
					return {17'h0, b0[6:0], b1};
				end
				KIND_EXT: begin
					if (need == 3'd2) return {16'h0, pair(b0, b1)};
					// 0x84 prefix: two words, first in the low half
					if (fill) return {pair(b2, b3), pair(b0, b1)};
					return quad();
				end
				KIND_SIZED: begin
					if (need == 3'd1) return {fill ? 24'hFFFFFF : 24'h0, b0};
					if (need == 3'd2) return {fill ? 16'hFFFF : 16'h0, pair(b0, b1)};
					return quad();
				end
				default: return {24'h0, b0};
			endcase
		endfunction

		function void push(logic [31:0] v, bit used);
			exp_value.push_back(v);
			exp_used.push_back(used);
			busy = 1'b0;
		endfunction

		// One accepted word: advance the field, queue a value if it completes
		function void note_word(logic [2:0] op_w, logic [2:0] code_w, logic [7:0] d);
			logic [1:0] len;
			bit         done;
			if (!busy) begin
				kind = (op_w == KIND_UNUSED) ? KIND_BYTE : op_w;
				acc = '0;
				taken = '0;
				fill = 1'b0;
				case (kind)
					KIND_WORD: need = 3'd2;
					KIND_LONG, KIND_SELF: need = 3'd4;
					KIND_SHORT: need = d[7] ? 3'd2 : 3'd1;
					KIND_EXT: begin
						// prefix is not part of the value
						if (d == PFX_WORD) begin
							need = 3'd2;
						end else if (d == PFX_PAIR) begin
							need = 3'd4;
							fill = 1'b1;
						end else if (d == PFX_LONG) begin
							need = 3'd4;
						end else begin
							push({24'h0, d}, 1'b1);
							return;
						end
						busy = 1'b1;
						return;
					end
					KIND_SIZED: begin
						len = code_w[1:0];
						// zero-length item ignores the data byte
						if (len == LEN_ZERO) begin
							push(code_w[2] ? 32'hFFFFFFFF : 32'h0, 1'b0);
							return;
						end
						need = (len == LEN_FOUR) ? 3'd4 : {1'b0, len};
						fill = (len == LEN_FOUR) ? 1'b0 : code_w[2];
					end
					default: need = 3'd1;
				endcase
				busy = 1'b1;
			end
			acc = acc | ({24'h0, d} << (taken[1:0] * 8));
			taken = taken + 3'd1;
			if (kind == KIND_SELF)
				done = (taken >= 3'd4) || (acc[8 - taken] == 1'b0);
			else
				done = (taken >= need);
			if (done)
				push(field_value(), 1'b1);
		endfunction

		function void check_value(logic [31:0] v, logic used);
			logic [31:0] ev;
			bit          eu;
			if (exp_value.size() == 0) begin
				$display("%0t: value %h consumed %b with nothing expected", $time, v, used);
				errors++;
				return;
			end
			ev = exp_value.pop_front();
			eu = exp_used.pop_front();
			checked++;
			if (v !== ev) begin
				$display("%0t: value expected %h actual %h", $time, ev, v);
				errors++;
			end
			if (used !== eu) begin
				$display("%0t: consumed expected %b actual %b", $time, eu, used);
				errors++;
			end
		endfunction

		function int waiting();
			return exp_value.size();
		endfunction

		function bit in_field();
			return busy;
		endfunction
	endclass

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic        cfg_wr_data = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  op = '0;
	logic [2:0]  size_code = '0;
	logic [7:0]  data_byte = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] value;
	logic        consumed;

	field_value_board board = new;
	bit idle_en = 1'b1;
	bit hold_req = 1'b0;
	int words_sent = 0;

	object_field_number_decoder_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.size_code(size_code),
		.data_byte(data_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.value(value),
		.consumed(consumed)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// watchdog
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("tb_object_field_number_decoder_core NOT OK");
		$finish;
	end

	// result side: check accepted words, stall at random or for a long hold-off
	initial begin
		int hold_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall)
				board.check_value(value, consumed);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= idle_en && ($urandom_range(0, 99) < 23);
			end
		end
	end

	// offer one word, optionally after a random gap, and wait for it to be taken
	task send_word(logic [2:0] k, logic [2:0] c, logic [7:0] d);
		if (idle_en && ($urandom_range(0, 99) < 23)) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= k;
		size_code <= c;
		data_byte <= d;
		do @(posedge clk); while (in_stall);
		board.note_word(k, c, d);
		words_sent++;
	endtask

	// directed field; bytes[7:0] goes first, follow-on words carry junk op/code
	task send_field(logic [2:0] k, logic [2:0] c, int n, logic [39:0] bytes);
		send_word(k, c, bytes[7:0]);
		for (int i = 1; i < n; i++)
			send_word(3'($urandom), 3'($urandom), bytes[i*8 +: 8]);
	endtask

	// mostly complete fields with random content, some lone noise words
	task send_random_field();
		logic [2:0] k;
		logic [2:0] c;
		logic [7:0] d;
		if ($urandom_range(0, 9) == 0) begin
			send_word(3'($urandom), 3'($urandom), 8'($urandom));
		end else begin
			k = 3'($urandom_range(0, 7));
			c = 3'($urandom);
			d = 8'($urandom);
			if (k == KIND_EXT) begin
				case ($urandom_range(0, 4))
					0: d = PFX_WORD;
					1: d = PFX_PAIR;
					2: d = PFX_LONG;
					default: ;
				endcase
			end else if (k == KIND_SELF) begin
				case ($urandom_range(0, 3))
					0: d[7] = 1'b0;
					1: d[7:6] = 2'b10;
					2: d[7:5] = 3'b110;
					default: d[7:5] = 3'b111;
				endcase
			end
			send_word(k, c, d);
			while (board.in_field())
				send_word(3'($urandom), 3'($urandom), 8'($urandom));
		end
	endtask

	task random_phase(int n);
		int target;
		target = words_sent + n;
		while (words_sent < target)
			send_random_field();
	endtask

	// stop offering until every expected value is back, then let the pipe settle
	task drain();
		in_valid <= 1'b0;
		while (board.waiting() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task set_byte_order(bit lo_first);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= lo_first;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		board.lbf = lo_first;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every kind, prefix, size code and byte extreme
		send_field(KIND_BYTE, 3'd0, 1, 40'h00);
		send_field(KIND_BYTE, 3'd7, 1, 40'hFF);
		send_field(KIND_UNUSED, 3'd0, 1, 40'hA5);
		send_field(KIND_WORD, 3'd0, 2, 40'h1234);
		send_field(KIND_LONG, 3'd0, 4, 40'h12345678);
		send_field(KIND_SELF, 3'd0, 1, 40'h7F);
		send_field(KIND_SELF, 3'd0, 2, 40'h2381);
		send_field(KIND_SELF, 3'd0, 3, 40'h3322C1);
		send_field(KIND_SELF, 3'd0, 4, 40'hCCDDEEFF);
		send_field(KIND_SHORT, 3'd0, 1, 40'h05);
		send_field(KIND_SHORT, 3'd0, 2, 40'h80FF);
		send_field(KIND_EXT, 3'd0, 3, 40'hBBAA81);
		send_field(KIND_EXT, 3'd0, 5, 40'h4433221184);
		send_field(KIND_EXT, 3'd0, 5, 40'hDDCCBBAA88);
		send_field(KIND_EXT, 3'd0, 1, 40'h42);
		send_field(KIND_SIZED, 3'd0, 1, 40'h5A);
		send_field(KIND_SIZED, 3'd4, 1, 40'h5A);
		send_field(KIND_SIZED, 3'd1, 1, 40'h80);
		send_field(KIND_SIZED, 3'd5, 1, 40'h80);
		send_field(KIND_SIZED, 3'd2, 2, 40'hBEEF);
		send_field(KIND_SIZED, 3'd6, 2, 40'h8001);
		send_field(KIND_SIZED, 3'd3, 4, 40'h89ABCDEF);
		send_field(KIND_SIZED, 3'd7, 4, 40'h89ABCDEF);
		drain();

		// high byte first, random idling on both sides
		set_byte_order(1'b0);
		random_phase(PHASE_WORDS);
		drain();

		// low byte first, no idling at all
		set_byte_order(1'b1);
		idle_en = 1'b0;
		random_phase(PHASE_WORDS);
		drain();
		idle_en = 1'b1;

		// high byte first with a long output hold-off to back the block up
		set_byte_order(1'b0);
		hold_req = 1'b1;
		random_phase(PHASE_WORDS);
		drain();

		set_byte_order(1'b1);
		random_phase(PHASE_WORDS);
		drain();

		$display("Sent %0d words and checked %0d values across every field kind,", words_sent,
			board.checked);
		$display("both byte orders, random idling, a no-idle stretch and a long output hold-off.");
		if (board.errors == 0 && board.waiting() == 0)
			$display("tb_object_field_number_decoder_core OK");
		else
			$display("tb_object_field_number_decoder_core NOT OK");
		$finish;
	end

endmodule
